// ===== design/mwom_pkg.sv =====
// Package for the waveform oscillator mixer: word types, register and waveform codes,
// and the quarter-wave sine table built at elaboration.
// No dependencies.
package mwom_pkg;

	localparam int SAMPLE_W        = 20;
	localparam int PHASE_W         = 32;
	localparam int STEP_W          = 32;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 32;
	localparam int WAVE_VAL_W      = 17;
	localparam int SINE_MAG_W      = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_TAB_M      = 1 << SINE_TABLE_BITS;
	localparam int SINE_TAB_N      = SINE_TAB_M + 1;
	localparam int SINE_ADDR_W     = SINE_TABLE_BITS + 1;

	localparam logic [PHASE_W-1:0] PHASE_HALF     = 32'h8000_0000;
	localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 32'd42852281;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] UNIT_Q15    = 64'd32768;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SQUARE   = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAVEFORM   = 2'd0,
		REG_PHASE_STEP = 2'd1
	} reg_index_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       last_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_out;
	} out_word_t;

	// what the first stage hands to the mixer
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic [PHASE_W-1:0]         phase;
	} stage_word_t;

	typedef logic [SINE_MAG_W-1:0] sine_tab_t [0:SINE_TAB_N-1];

	// sin(pi/2 * k / M) in Q.15, Horner Taylor series in unsigned Q30
	function automatic logic [SINE_MAG_W-1:0] sine_q15(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] r;
		logic [63:0] s;
		x  = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		r  = ONE_Q30;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd210;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd156;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd110;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd72;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd42;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd20;
		r  = ONE_Q30 - ((x2 * r) >> 30) / 64'd6;
		s  = (x * r) >> 30;
		s  = (s + (64'd1 << 14)) >> 15;
		if (s > UNIT_Q15) begin
			s = UNIT_Q15;
		end
		return s[SINE_MAG_W-1:0];
	endfunction

	function automatic sine_tab_t build_sine_table();
		sine_tab_t t;
		for (int k = 0; k < SINE_TAB_N; k++) begin
			t[k] = sine_q15(k);
		end
		return t;
	endfunction

endpackage

// ===== design/mwom_sine_rom.sv =====
// Quarter-wave sine magnitude table with a registered read port.
// Depends on mwom_pkg for the table depth, width and contents.
module mwom_sine_rom (
	input  logic                                clk,
	input  logic                                en,
	input  logic [mwom_pkg::SINE_ADDR_W-1:0]    addr,
	output logic [mwom_pkg::SINE_MAG_W-1:0]     data
);

	localparam mwom_pkg::sine_tab_t SINE_TABLE = mwom_pkg::build_sine_table();

	logic [mwom_pkg::SINE_MAG_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= SINE_TABLE[addr];
		end
	end

	assign data = data_q;

endmodule

// ===== design/mwom_wave_mix.sv =====
// Waveform select, add to the sample and saturate to the Q4.15 range.
// Depends on mwom_pkg for word types and waveform codes.
module mwom_wave_mix (
	input  mwom_pkg::wave_t                 waveform,
	input  mwom_pkg::stage_word_t           stage,
	input  logic [mwom_pkg::SINE_MAG_W-1:0] sine_mag,
	output mwom_pkg::out_word_t             result
);

	localparam int WIDE_W = mwom_pkg::WAVE_VAL_W + 2;
	localparam int SUM_W  = mwom_pkg::SAMPLE_W + 1;

	localparam logic signed [WIDE_W-1:0] UNIT   = WIDE_W'(32768);
	localparam logic signed [WIDE_W-1:0] THREE  = WIDE_W'(98304);
	localparam logic signed [SUM_W-1:0]  S_MAX  = SUM_W'(524287);
	localparam logic signed [SUM_W-1:0]  S_MIN  = -SUM_W'(524288);

	logic signed [WIDE_W-1:0]               wide;
	logic signed [mwom_pkg::WAVE_VAL_W-1:0] wave;
	logic signed [WIDE_W-1:0]               sine_s;
	logic signed [WIDE_W-1:0]               saw_s;
	logic signed [WIDE_W-1:0]               tri_s;
	logic signed [SUM_W-1:0]                sum;
	logic signed [SUM_W-1:0]                sat;

	always_comb begin
		sine_s = $signed({{(WIDE_W-mwom_pkg::SINE_MAG_W){1'b0}}, sine_mag});
		saw_s  = $signed({{(WIDE_W-16){1'b0}}, stage.phase[31:16]});
		tri_s  = $signed({{(WIDE_W-17){1'b0}}, stage.phase[31:15]});
		case (waveform)
			mwom_pkg::WAVE_SINE: begin
				// quadrants three and four are the negated half
				wide = stage.phase[31] ? -sine_s : sine_s;
			end
			mwom_pkg::WAVE_SQUARE: begin
				if (stage.phase == '0 || stage.phase == mwom_pkg::PHASE_HALF) begin
					wide = '0;
				end else begin
					wide = stage.phase[31] ? -UNIT : UNIT;
				end
			end
			mwom_pkg::WAVE_SAW: begin
				wide = saw_s - UNIT;
			end
			default: begin
				wide = stage.phase[31] ? (THREE - tri_s) : (tri_s - UNIT);
			end
		endcase
		wave = wide[mwom_pkg::WAVE_VAL_W-1:0];
		sum  = SUM_W'(stage.sample) + SUM_W'(wave);
		if (sum > S_MAX) begin
			sat = S_MAX;
		end else if (sum < S_MIN) begin
			sat = S_MIN;
		end else begin
			sat = sum;
		end
		result.sample_out = sat[mwom_pkg::SAMPLE_W-1:0];
		result.last_out   = stage.last;
	end

endmodule

// ===== design/multi_waveform_oscillator_mixer.sv =====
// Adds a sine, square, sawtooth or triangle wave from a 32-bit phase accumulator to each
// Q4.15 sample word, saturating the sum; the phase restarts at zero after a word marked last.
// One word is taken every cycle while results are taken, and its result reaches the output
// through the pipeline registers: the edge that accepts it registers the word together with the
// sine table read, a later edge registers the mixed, saturated result. Input stalls only when
// both registers hold a word and the result is not taken. Configuration writes are taken
// in any cycle (ready is tied high) and must be made while the block is idle. Depends on
// mwom_pkg, mwom_sine_rom and mwom_wave_mix.
module multi_waveform_oscillator_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mwom_pkg::in_word_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mwom_pkg::out_word_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mwom_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mwom_pkg::CFG_DATA_W-1:0]    cfg_data
);

	mwom_pkg::wave_t                  waveform_q;
	logic [mwom_pkg::STEP_W-1:0]      phase_step_q;
	logic [mwom_pkg::PHASE_W-1:0]     phase_q;

	logic                             valid_s1;
	mwom_pkg::stage_word_t            word_s1;
	logic                             valid_s2;
	mwom_pkg::out_word_t              word_s2;

	logic                                  in_acc;
	logic                                  load_s2;
	logic [mwom_pkg::SINE_TABLE_BITS-1:0]  tab_k;
	logic [mwom_pkg::SINE_ADDR_W-1:0]      tab_addr;
	logic [mwom_pkg::SINE_MAG_W-1:0]       sine_mag;
	mwom_pkg::out_word_t                   mixed;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || !valid_s2 || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign load_s2   = valid_s1 && (!valid_s2 || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= mwom_pkg::WAVE_SINE;
			phase_step_q <= mwom_pkg::PHASE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mwom_pkg::REG_WAVEFORM: begin
					waveform_q <= mwom_pkg::wave_t'(cfg_data[1:0]);
				end
				mwom_pkg::REG_PHASE_STEP: begin
					phase_step_q <= cfg_data[mwom_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_acc) begin
			phase_q <= in_data.last_sample ? '0 : phase_q + phase_step_q;
		end
	end

	// mirrored table index in the second and fourth quadrants
	assign tab_k    = phase_q[29 -: mwom_pkg::SINE_TABLE_BITS];
	assign tab_addr = phase_q[30] ?
		(mwom_pkg::SINE_ADDR_W'(mwom_pkg::SINE_TAB_M) - {1'b0, tab_k}) : {1'b0, tab_k};

	mwom_sine_rom u_sine_rom (
		.clk  (clk),
		.en   (in_acc),
		.addr (tab_addr),
		.data (sine_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1.sample <= in_data.sample_in;
			word_s1.last   <= in_data.last_sample;
			word_s1.phase  <= phase_q;
		end
	end

	mwom_wave_mix u_wave_mix (
		.waveform (waveform_q),
		.stage    (word_s1),
		.sine_mag (sine_mag),
		.result   (mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			word_s2 <= mixed;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = word_s2;

	a_s1_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && valid_s1) |-> load_s2)
		else $error("first stage word overwritten before it moved on");

	a_phase_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_data.last_sample) |=> (phase_q == '0))
		else $error("phase did not restart after last word");

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_data.last_sample) |=>
		(phase_q == $past(phase_q + phase_step_q)))
		else $error("phase did not advance by the step");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result word appeared without a first stage word");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty first stage");

endmodule
